### sv/sdrb_pkg.sv
// Shared types, widths and register indexes for the straight-drive speed profile.
package sdrb_pkg;

    // Configuration channel
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 24;

    localparam logic [CFG_IW-1:0] CFG_TARGET   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_MAX_PWR  = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_BRAKE    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_BAND     = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_RAMP     = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_POLARITY = 3'd5;

    localparam logic [6:0] MAX_PWR_RESET = 7'd127;

    // Short divider: quotient is known to stay below 2**DIV_QW
    localparam int DIV_NW = 30;
    localparam int DIV_DW = 23;
    localparam int DIV_QW = 7;
    localparam int DIV_SW = $clog2(DIV_QW);
    localparam logic [DIV_SW-1:0] DIV_LAST = DIV_SW'(DIV_QW - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_ABS,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_WRITE
    } state_t;

    // Step strobes from the sequencer to the lanes and the merge stage
    typedef struct packed {
        logic calc;
        logic absv;
        logic mul;
        logic go;
    } step_ctrl_t;

    // What one wheel lane reports to the merge stage
    typedef struct packed {
        logic       lt_thr;
        logic       gt_thr;
        logic       in_band;
        logic       busy;
        logic [7:0] speed;
    } lane_res_t;

endpackage

### sv/sdrb_div.sv
// Iterative restoring divider, one quotient bit per cycle, quotient below 2**DIV_QW.
module sdrb_div
    import sdrb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic [DIV_QW-1:0] quotient,
    output logic              busy
);

    logic              busy_reg, busy_next;
    logic [DIV_SW-1:0] step_reg, step_next;
    logic [DIV_NW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] dvs_reg, dvs_next;
    logic [DIV_QW-1:0] quo_reg, quo_next;
    logic [DIV_NW-1:0] d_shift;
    logic [DIV_NW-1:0] trial;
    logic              fits;

    assign d_shift = DIV_NW'(dvs_reg) << step_reg;
    assign trial   = rem_reg - d_shift;
    assign fits    = rem_reg >= d_shift;

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (go)
        begin
            busy_next = 1'b1;
            step_next = DIV_LAST;
            rem_next  = dividend;
            dvs_next  = divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next           = trial;
                quo_next[step_reg] = 1'b1;
            end
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;

endmodule

### sv/sdrb_lane.sv
// One wheel lane: distance moved, error to target, braking speed and stop band check.
module sdrb_lane
    import sdrb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  step_ctrl_t         ctrl,
    input  logic [31:0]        count,
    input  logic [31:0]        base,
    input  logic               enc_inv,
    input  logic signed [23:0] target,
    input  logic [22:0]        brake,
    input  logic [15:0]        band,
    input  logic [6:0]         max_power,
    output lane_res_t          res
);

    logic [31:0]        diff;
    logic signed [32:0] moved_c;
    logic signed [33:0] tgt34;
    logic signed [33:0] thr34;
    logic signed [33:0] err_c;

    logic signed [32:0] moved_reg;
    logic signed [33:0] err_reg;
    logic signed [33:0] neg_err;
    logic [32:0]        mag_reg;
    logic               neg_reg;
    logic               lt_reg;
    logic               gt_reg;
    logic [DIV_NW-1:0]  prod_c;
    logic               big_reg;
    logic               zero_reg;
    logic               band_reg;

    logic [DIV_QW-1:0]  quo;
    logic               div_busy;
    logic [6:0]         spd_mag;
    logic [7:0]         mag8;

    assign diff    = count - base;
    assign moved_c = enc_inv ? -$signed({diff[31], diff}) : $signed({diff[31], diff});
    assign tgt34   = 34'(target);
    assign thr34   = tgt34 - $signed(34'(brake));
    assign err_c   = tgt34 - 34'(moved_reg);
    assign neg_err = -err_reg;

    // Divide only matters when |err| < brake, so the low bits carry it all
    assign prod_c  = DIV_NW'(mag_reg[22:0]) * DIV_NW'(max_power);

    always_ff @(posedge clk)
    begin
        if (ctrl.calc)
        begin
            moved_reg <= moved_c;
        end
        if (ctrl.absv)
        begin
            err_reg <= err_c;
            lt_reg  <= 34'(moved_reg) < thr34;
            gt_reg  <= 34'(moved_reg) > thr34;
        end
        if (ctrl.mul)
        begin
            mag_reg <= err_reg[33] ? neg_err[32:0] : err_reg[32:0];
            neg_reg <= err_reg[33];
        end
        if (ctrl.go)
        begin
            big_reg  <= mag_reg >= 33'(brake);
            zero_reg <= (mag_reg == '0) || (max_power == '0);
            band_reg <= mag_reg < 33'(band);
        end
    end

    sdrb_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (ctrl.go),
        .dividend (prod_c),
        .divisor  (brake),
        .quotient (quo),
        .busy     (div_busy)
    );

    // Outside the linear zone the speed saturates at full power
    assign spd_mag = big_reg ? max_power : quo;
    assign mag8    = zero_reg ? 8'd0 : {1'b0, spd_mag};

    always_comb
    begin
        res.lt_thr  = lt_reg;
        res.gt_thr  = gt_reg;
        res.in_band = band_reg;
        res.busy    = div_busy;
        res.speed   = neg_reg ? 8'd0 - mag8 : mag8;
    end

endmodule

### sv/sdrb_merge.sv
// Merge stage: ramp speed, profile phase choice, stop band finish and motor polarity.
module sdrb_merge
    import sdrb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  step_ctrl_t  ctrl,
    input  logic [31:0] elapsed,
    input  logic [15:0] ramp_ms,
    input  logic [6:0]  max_power,
    input  logic [1:0]  motor_inv,
    input  lane_res_t   left_res,
    input  lane_res_t   right_res,
    output logic [7:0]  left_drive,
    output logic [7:0]  right_drive,
    output logic        finish,
    output logic        busy
);

    logic              ramp_ok_reg;
    logic [DIV_NW-1:0] ramp_prod_reg;
    logic [DIV_QW-1:0] ramp_quo;
    logic              ramp_busy;
    logic [7:0]        left_spd;
    logic [7:0]        right_spd;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            ramp_ok_reg <= elapsed < 32'(ramp_ms);
        end
        if (ctrl.mul)
        begin
            // elapsed below ramp_ms keeps the product within 23 bits
            ramp_prod_reg <= DIV_NW'(elapsed[15:0]) * DIV_NW'(max_power);
        end
    end

    sdrb_div u_ramp_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (ctrl.go),
        .dividend (ramp_prod_reg),
        .divisor  (DIV_DW'(ramp_ms)),
        .quotient (ramp_quo),
        .busy     (ramp_busy)
    );

    assign finish = left_res.in_band && right_res.in_band;
    assign busy   = ramp_busy;

    always_comb
    begin
        priority if (ramp_ok_reg && left_res.lt_thr && right_res.lt_thr)
        begin
            left_spd  = {1'b0, ramp_quo};
            right_spd = {1'b0, ramp_quo};
        end
        else if (left_res.gt_thr || right_res.gt_thr)
        begin
            left_spd  = left_res.speed;
            right_spd = right_res.speed;
        end
        else
        begin
            left_spd  = {1'b0, max_power};
            right_spd = {1'b0, max_power};
        end
        if (finish)
        begin
            left_spd  = 8'd0;
            right_spd = 8'd0;
        end
        left_drive  = motor_inv[0] ? 8'd0 - left_spd : left_spd;
        right_drive = motor_inv[1] ? 8'd0 - right_spd : right_spd;
    end

endmodule

### sv/straight_drive_ramp_brake_profile_core.sv
// Top level: request intake, start latching, step sequencer, lanes, merge and result register.
//
// Straight-drive speed profile. Each request on the s_ channel is one control tick
// (time in ms, start flag, two raw encoder counts); each tick yields one result on
// the m_ channel with both motor commands and the sticky finished flag.
// A request with start set latches the time and encoder baselines and clears the flag.
// Configuration goes through the cfg_ channel (index per register, data in the low
// bits); cfg_ready is always high and writes are meant only while no tick is in flight.
// An accepted request steps through the calc, abs, mul, divider start and divider wait
// states, then the write state loads the result register; only after that is the next
// request taken. The three 7-step dividers (left brake, right brake, ramp) run side by
// side in the wait state. Reset clears the baselines, start time, flag and sequencer;
// max_power returns to 127 and all other configuration registers to zero. When the
// receiver stalls, the finished result is held in the output register; one more request
// can be processed meanwhile and then waits until the output register frees up.
module straight_drive_ramp_brake_profile_core
    import sdrb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [95:0]       s_tdata,   // now_ms[31:0], left_count[63:32], right_count[95:64]
    input  logic              s_tuser,   // start_req
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // left_drive[7:0], right_drive[15:8]
    output logic              m_tuser,   // done_res
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [CFG_DW-1:0] cfg_data
);

    state_t             state_reg, state_next;
    step_ctrl_t         ctrl;
    logic               load_out;
    logic               accept;
    logic               out_free;

    logic signed [23:0] target_reg;
    logic [6:0]         max_power_reg;
    logic [22:0]        brake_reg;
    logic [15:0]        band_reg;
    logic [15:0]        ramp_reg;
    logic [3:0]         pol_reg;

    logic [31:0]        start_time_reg;
    logic [31:0]        left_base_reg;
    logic [31:0]        right_base_reg;
    logic               done_reg, done_next;
    logic [31:0]        now_reg;
    logic [31:0]        left_cnt_reg;
    logic [31:0]        right_cnt_reg;
    logic [31:0]        elapsed_reg;

    lane_res_t          left_res;
    lane_res_t          right_res;
    logic [7:0]         left_drive;
    logic [7:0]         right_drive;
    logic               finish;
    logic               merge_busy;
    logic               any_busy;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [15:0]        m_tdata_reg;
    logic               m_tuser_reg;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign any_busy  = left_res.busy || right_res.busy || merge_busy;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            max_power_reg <= MAX_PWR_RESET;
            brake_reg     <= '0;
            band_reg      <= '0;
            ramp_reg      <= '0;
            pol_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TARGET:   target_reg    <= $signed(cfg_data[23:0]);
                CFG_MAX_PWR:  max_power_reg <= cfg_data[6:0];
                CFG_BRAKE:    brake_reg     <= cfg_data[22:0];
                CFG_BAND:     band_reg      <= cfg_data[15:0];
                CFG_RAMP:     ramp_reg      <= cfg_data[15:0];
                CFG_POLARITY: pol_reg       <= cfg_data[3:0];
                default:      ;
            endcase
        end
    end

    // Sequencer: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_tvalid) state_next = ST_CALC;
            ST_CALC:     state_next = ST_ABS;
            ST_ABS:      state_next = ST_MUL;
            ST_MUL:      state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: if (!any_busy) state_next = ST_WRITE;
            ST_WRITE:    if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        s_tready  = 1'b0;
        ctrl.calc = 1'b0;
        ctrl.absv = 1'b0;
        ctrl.mul  = 1'b0;
        ctrl.go   = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:     s_tready  = 1'b1;
            ST_CALC:     ctrl.calc = 1'b1;
            ST_ABS:      ctrl.absv = 1'b1;
            ST_MUL:      ctrl.mul  = 1'b1;
            ST_DIV_GO:   ctrl.go   = 1'b1;
            ST_DIV_WAIT: ;
            ST_WRITE:    load_out  = out_free;
            default:     ;
        endcase
    end

    always_comb
    begin
        done_next = done_reg;
        if (accept && s_tuser)
        begin
            done_next = 1'b0;
        end
        else if (load_out && finish)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            start_time_reg <= '0;
            left_base_reg  <= '0;
            right_base_reg <= '0;
            done_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            done_reg     <= done_next;
            m_tvalid_reg <= m_tvalid_next;
            if (accept && s_tuser)
            begin
                start_time_reg <= s_tdata[31:0];
                left_base_reg  <= s_tdata[63:32];
                right_base_reg <= s_tdata[95:64];
            end
        end
    end

    // Request payload and elapsed time
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg       <= s_tdata[31:0];
            left_cnt_reg  <= s_tdata[63:32];
            right_cnt_reg <= s_tdata[95:64];
        end
        if (ctrl.calc)
        begin
            elapsed_reg <= now_reg - start_time_reg;
        end
    end

    sdrb_lane u_left
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .count     (left_cnt_reg),
        .base      (left_base_reg),
        .enc_inv   (pol_reg[0]),
        .target    (target_reg),
        .brake     (brake_reg),
        .band      (band_reg),
        .max_power (max_power_reg),
        .res       (left_res)
    );

    sdrb_lane u_right
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .count     (right_cnt_reg),
        .base      (right_base_reg),
        .enc_inv   (pol_reg[1]),
        .target    (target_reg),
        .brake     (brake_reg),
        .band      (band_reg),
        .max_power (max_power_reg),
        .res       (right_res)
    );

    sdrb_merge u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .elapsed     (elapsed_reg),
        .ramp_ms     (ramp_reg),
        .max_power   (max_power_reg),
        .motor_inv   (pol_reg[3:2]),
        .left_res    (left_res),
        .right_res   (right_res),
        .left_drive  (left_drive),
        .right_drive (right_drive),
        .finish      (finish),
        .busy        (merge_busy)
    );

    // Result register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            m_tdata_reg <= {right_drive, left_drive};
            m_tuser_reg <= done_reg || finish;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The finished flag survives every tick that is not a start
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && !(accept && s_tuser) |=> done_reg)
        else $error("finished flag dropped without a start");

    // No new request while any divider still iterates
    assert property (@(posedge clk) disable iff (!rst_n)
        any_busy |-> !s_tready)
        else $error("request taken while dividers busy");

    // A tick inside the stop band drives both motors to zero and reports finished
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out && finish |=> m_tvalid && (m_tdata == 16'd0) && m_tuser)
        else $error("stop band result not zero or not finished");

    // A loaded result is never overwritten before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !m_tvalid_reg || m_tready)
        else $error("result register overwritten while stalled");

endmodule

### dv/straight_drive_ramp_brake_profile_core_test.sv
// Self-checking testbench for the straight-drive ramp/brake speed profile core.
module straight_drive_ramp_brake_profile_core_test;
    import sdrb_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 20;

    typedef struct packed {
        logic        start;
        logic [31:0] now;
        logic [31:0] lc;
        logic [31:0] rc;
    } tick_t;

    typedef struct packed {
        logic [7:0] left;
        logic [7:0] right;
        logic       done;
    } drive_t;

    typedef enum logic [1:0] {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_BEAT} rx_mode_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [95:0]       s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;
    logic              m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data = '0;

    straight_drive_ramp_brake_profile_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Register shadow and move state of the profile predictor
    logic signed [23:0] cfg_target = '0;
    logic [6:0]         cfg_maxp   = MAX_PWR_RESET;
    logic [22:0]        cfg_brake  = '0;
    logic [15:0]        cfg_band   = '0;
    logic [15:0]        cfg_ramp   = '0;
    logic [3:0]         cfg_pol    = '0;
    logic [31:0]        mv_t0      = '0;
    logic [31:0]        mv_lbase   = '0;
    logic [31:0]        mv_rbase   = '0;
    logic               mv_done    = 1'b0;

    tick_t  tick_q[$];
    drive_t drive_q[$];
    int     pushed_n = 0;
    int     checked_n = 0;
    int     errors = 0;
    int     stall_cycles = 0;

    bit       s_taken = 1'b0;
    int       burst_left = 1;
    int       gap_left = 0;
    bit       hold_req = 1'b0;
    int       hold_left = 0;
    rx_mode_t rx_mode = RX_FREE;
    int       mode_left = 0;
    logic [1:0] beat_cnt = '0;

    function automatic longint brake_cmd(longint dist_left);
        longint m;
        longint b;
        longint num;
        m = cfg_maxp;
        b = cfg_brake;
        num = dist_left * m;
        // zero braking distance saturates on the sign of the numerator
        if (b == 0)
            return (num > 0) ? m : ((num < 0) ? -m : 0);
        return num / b;
    endfunction

    function automatic longint clamp_cmd(longint s);
        longint m;
        m = cfg_maxp;
        if (s > m)
            return m;
        if (s < -m)
            return -m;
        return s;
    endfunction

    function automatic drive_t drive_for_tick(tick_t t);
        logic [31:0] elapsed;
        logic [31:0] dl;
        logic [31:0] dr;
        longint le, lr, m, goal, thr, ml, mr, ls, rs, el, er, band;
        drive_t r;
        if (t.start)
        begin
            mv_t0 = t.now;
            mv_lbase = t.lc;
            mv_rbase = t.rc;
            mv_done = 1'b0;
        end
        elapsed = t.now - mv_t0;
        dl = t.lc - mv_lbase;
        dr = t.rc - mv_rbase;
        le = elapsed;
        lr = cfg_ramp;
        m = cfg_maxp;
        band = cfg_band;
        goal = cfg_target;
        ml = $signed(dl);
        mr = $signed(dr);
        if (cfg_pol[0])
            ml = -ml;
        if (cfg_pol[1])
            mr = -mr;
        thr = goal - longint'(cfg_brake);
        if (le < lr && ml < thr && mr < thr)
        begin
            ls = (le * m) / lr;
            rs = ls;
        end
        else if (ml > thr || mr > thr)
        begin
            ls = brake_cmd(goal - ml);
            rs = brake_cmd(goal - mr);
        end
        else
        begin
            ls = m;
            rs = m;
        end
        ls = clamp_cmd(ls);
        rs = clamp_cmd(rs);
        el = goal - ml;
        er = goal - mr;
        if (el < 0)
            el = -el;
        if (er < 0)
            er = -er;
        if (el < band && er < band)
        begin
            mv_done = 1'b1;
            ls = 0;
            rs = 0;
        end
        if (cfg_pol[2])
            ls = -ls;
        if (cfg_pol[3])
            rs = -rs;
        r.left = ls[7:0];
        r.right = rs[7:0];
        r.done = mv_done;
        return r;
    endfunction

    // Request driver: bursts of random length separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || s_taken))
        begin
            s_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (tick_q.size() > 0)
            begin
                tick_t t;
                t = tick_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {t.rc, t.lc, t.now};
                s_tuser <= t.start;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left--;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Result receiver: own stall pattern, plus one long hold-off on demand
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD;
            m_tready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            beat_cnt = beat_cnt + 2'd1;
            case (rx_mode)
                RX_FREE:   m_tready <= 1'b1;
                RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= beat_cnt[1];
            endcase
        end
    end

    // Predict on request accept, check on result accept
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                drive_q.push_back(drive_for_tick(
                    tick_t'{s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]}));
                s_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                checked_n++;
                if (drive_q.size() == 0)
                begin
                    $error("result with no request pending: %h/%b", m_tdata, m_tuser);
                    errors++;
                end
                else
                begin
                    drive_t want;
                    want = drive_q.pop_front();
                    if (m_tdata[7:0] !== want.left)
                    begin
                        $error("left_drive: expected %0d, got %0d",
                               $signed(want.left), $signed(m_tdata[7:0]));
                        errors++;
                    end
                    if (m_tdata[15:8] !== want.right)
                    begin
                        $error("right_drive: expected %0d, got %0d",
                               $signed(want.right), $signed(m_tdata[15:8]));
                        errors++;
                    end
                    if (m_tuser !== want.done)
                    begin
                        $error("done_res: expected %0d, got %0d", want.done, m_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_tick(bit start, logic [31:0] now, logic [31:0] lc, logic [31:0] rc);
        tick_q.push_back(tick_t'{start, now, lc, rc});
        pushed_n++;
    endtask

    task automatic wait_idle();
        while (checked_n < pushed_n)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_TARGET:   cfg_target = val[23:0];
            CFG_MAX_PWR:  cfg_maxp = val[6:0];
            CFG_BRAKE:    cfg_brake = val[22:0];
            CFG_BAND:     cfg_band = val[15:0];
            CFG_RAMP:     cfg_ramp = val[15:0];
            CFG_POLARITY: cfg_pol = val[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_profile(longint tgt, int maxp, int brake, int band, int ramp, int pol);
        wait_idle();
        write_reg(CFG_TARGET, CFG_DW'(tgt));
        write_reg(CFG_MAX_PWR, CFG_DW'(maxp));
        write_reg(CFG_BRAKE, CFG_DW'(brake));
        write_reg(CFG_BAND, CFG_DW'(band));
        write_reg(CFG_RAMP, CFG_DW'(ramp));
        write_reg(CFG_POLARITY, CFG_DW'(pol));
    endtask

    task automatic random_profile();
        longint tgt;
        int maxp, brake, band, ramp;
        case ($urandom_range(0, 5))
            0: tgt = -8388608;
            1: tgt = 8388607;
            2: tgt = 0;
            default: tgt = longint'($urandom_range(0, 40000)) - 20000;
        endcase
        case ($urandom_range(0, 4))
            0: maxp = 0;
            1: maxp = 127;
            default: maxp = $urandom_range(1, 127);
        endcase
        case ($urandom_range(0, 4))
            0: brake = 0;
            1: brake = 8388607;
            2: brake = $urandom_range(1, 50);
            default: brake = $urandom_range(1, (tgt < 0 ? -tgt : tgt) / 2 + 100);
        endcase
        case ($urandom_range(0, 4))
            0: band = 0;
            1: band = 65535;
            default: band = $urandom_range(1, 60);
        endcase
        case ($urandom_range(0, 4))
            0: ramp = 0;
            1: ramp = 65535;
            default: ramp = $urandom_range(1, 600);
        endcase
        set_profile(tgt, maxp, brake, band, ramp, $urandom_range(0, 15));
    endtask

    // One move: start, approach the target, settle around it, sometimes overshoot
    task automatic queue_move(int n);
        logic [31:0] now0, lc0, rc0, dt;
        longint tgt, cap, ml, mr, lraw, rraw;
        tgt = cfg_target;
        cap = longint'(cfg_band) + 2;
        now0 = $urandom;
        lc0 = $urandom;
        rc0 = $urandom;
        dt = $urandom_range(1, 40);
        for (int k = 0; k < n; k++)
        begin
            if (k < n - 4)
            begin
                ml = tgt * k / (n - 4) + longint'($urandom_range(0, 6)) - 3;
                mr = tgt * k / (n - 4) + longint'($urandom_range(0, 6)) - 3;
            end
            else
            begin
                ml = tgt + longint'($urandom_range(0, 2 * cap)) - cap;
                mr = tgt + longint'($urandom_range(0, 2 * cap)) - cap;
            end
            if (k == n - 1 && $urandom_range(0, 2) == 0)
                ml = tgt + ((tgt >= 0) ? 1 : -1) * (cap + $urandom_range(0, 200));
            lraw = cfg_pol[0] ? -ml : ml;
            rraw = cfg_pol[1] ? -mr : mr;
            push_tick(k == 0 || (k == n / 2 && $urandom_range(0, 15) == 0),
                      now0 + dt * k, lc0 + lraw[31:0], rc0 + rraw[31:0]);
        end
    endtask

    initial
    begin
        int base;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // No start yet, reset registers: zero ramp, zero brake, zero band
        push_tick(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        push_tick(1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        push_tick(1'b1, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0000_0001);
        push_tick(1'b0, 32'h1234_5679, 32'h8000_0000, 32'h7FFF_FFFF);

        // Ramp, cruise, brake, finish, finished outside band, restart
        set_profile(1000, 100, 300, 10, 200, 0);
        push_tick(1'b1, 100, 0, 0);
        push_tick(1'b0, 200, 20, 25);
        push_tick(1'b0, 400, 400, 410);
        push_tick(1'b0, 500, 800, 780);
        push_tick(1'b0, 520, 995, 1004);
        push_tick(1'b0, 540, 1200, 1100);
        push_tick(1'b1, 560, 1200, 1100);

        // Zero brake distance saturation, time wrap, all polarities inverted
        set_profile(-5000, 127, 0, 0, 65535, 15);
        push_tick(1'b1, 32'hFFFF_FFF0, 0, 0);
        push_tick(1'b0, 32'h0000_0010, 5000, 4000);
        push_tick(1'b0, 32'h0000_0020, 6000, -100);
        push_tick(1'b0, 32'h0000_0030, 100, 200);

        // Zero max power, widest band and brake
        set_profile(8388607, 0, 8388607, 65535, 0, 5);
        push_tick(1'b1, 0, 0, 0);
        push_tick(1'b0, 100, -8388607, 8388607);
        push_tick(1'b0, 200, 32'h8000_0000, 32'h7FFF_FFFF);

        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 0)
                set_profile(8388607, 127, 8388607, 65535, 65535, 15);
            else if (ph == 1)
                set_profile(-8388608, 0, 0, 0, 0, 0);
            else
                random_profile();
            if (ph == 3)
                hold_req = 1'b1;
            base = pushed_n;
            while (pushed_n - base < 70)
            begin
                if ($urandom_range(0, 7) == 0)
                    push_tick($urandom_range(0, 9) == 0, $urandom, $urandom, $urandom);
                else
                    queue_move($urandom_range(8, 24));
            end
        end

        wait_idle();
        if (errors == 0 && drive_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
